/* rtl/orsp_pkg.sv */
package orsp_pkg;

    localparam logic [15:0] HDR_CODE   = 16'hCADE;
    localparam logic [15:0] HDR_DATA   = 16'hDADA;
    localparam logic [15:0] HDR_SYMBOL = 16'hC3B7;

    localparam logic [1:0] PH_HEADER = 2'd0;
    localparam logic [1:0] PH_ADDR   = 2'd1;
    localparam logic [1:0] PH_COUNT  = 2'd2;
    localparam logic [1:0] PH_BODY   = 2'd3;

    localparam logic [2:0] KIND_WORD   = 3'd0;
    localparam logic [2:0] KIND_SYMBOL = 3'd1;
    localparam logic [2:0] KIND_DONE   = 3'd2;
    localparam logic [2:0] KIND_BAD    = 3'd3;
    localparam logic [2:0] KIND_TRUNC  = 3'd4;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_stream;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] target_address;
        logic [15:0] value;
        logic        last_of_section;
    } t_out_item;

    typedef struct packed {
        logic [1:0]  phase;
        logic [7:0]  high_byte_hold;
        logic        have_high_byte;
        logic        section_is_symbol;
        logic [15:0] current_address;
        logic [15:0] remaining_count;
        logic        failed;
    } t_parse_state;

endpackage

/* rtl/orsp_core.sv */
module orsp_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  orsp_pkg::t_in_item  i_item,
    output logic              o_res_valid,
    output orsp_pkg::t_out_item o_res
);
    import orsp_pkg::*;

    t_parse_state r_st;
    t_parse_state n_st;
    logic [15:0]  word;
    logic         last;

    assign word = {r_st.high_byte_hold, i_item.data_byte};
    assign last = (r_st.remaining_count == 16'd1);

    always_comb begin
        n_st        = r_st;
        o_res_valid = 1'b0;
        o_res       = '0;
        if (i_item.end_of_stream) begin
            o_res_valid = !r_st.failed;
            o_res.kind  = (r_st.phase == PH_HEADER && !r_st.have_high_byte)
                          ? KIND_DONE : KIND_TRUNC;
            n_st        = '0;
        end else if (r_st.failed) begin
            n_st = r_st;
        end else if (r_st.phase == PH_BODY && r_st.section_is_symbol) begin
            // symbol bodies are single bytes, never paired
            n_st.remaining_count  = r_st.remaining_count - 16'd1;
            if (last) begin
                n_st.phase = PH_HEADER;
            end
            o_res_valid           = 1'b1;
            o_res.kind            = KIND_SYMBOL;
            o_res.target_address  = r_st.current_address;
            o_res.value           = {8'd0, i_item.data_byte};
            o_res.last_of_section = last;
        end else if (!r_st.have_high_byte) begin
            n_st.high_byte_hold = i_item.data_byte;
            n_st.have_high_byte = 1'b1;
        end else begin
            n_st.have_high_byte = 1'b0;
            unique case (r_st.phase)
                PH_HEADER: begin
                    if (word == HDR_CODE || word == HDR_DATA) begin
                        n_st.section_is_symbol = 1'b0;
                        n_st.phase             = PH_ADDR;
                    end else if (word == HDR_SYMBOL) begin
                        n_st.section_is_symbol = 1'b1;
                        n_st.phase             = PH_ADDR;
                    end else begin
                        n_st.failed = 1'b1;
                        o_res_valid = 1'b1;
                        o_res.kind  = KIND_BAD;
                        o_res.value = word;
                    end
                end
                PH_ADDR: begin
                    n_st.current_address = word;
                    n_st.phase           = PH_COUNT;
                end
                PH_COUNT: begin
                    n_st.remaining_count = word;
                    n_st.phase           = (word == 16'd0) ? PH_HEADER : PH_BODY;
                end
                PH_BODY: begin
                    n_st.current_address  = r_st.current_address + 16'd1;
                    n_st.remaining_count  = r_st.remaining_count - 16'd1;
                    if (last) begin
                        n_st.phase = PH_HEADER;
                    end
                    o_res_valid           = 1'b1;
                    o_res.kind            = KIND_WORD;
                    o_res.target_address  = r_st.current_address;
                    o_res.value           = word;
                    o_res.last_of_section = last;
                end
                default: n_st = r_st;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= '0;
        end else if (i_fire) begin
            r_st <= n_st;
        end
    end

    // once failed, only an end-of-stream beat may leave this state
    a_failed_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && r_st.failed && !i_item.end_of_stream |-> !o_res_valid)
        else $error("result produced after bad header");

    a_eos_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && i_item.end_of_stream |=> r_st == '0)
        else $error("state not cleared after end of stream");

    a_symbol_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_res.kind == KIND_SYMBOL |->
        r_st.section_is_symbol && r_st.phase == PH_BODY)
        else $error("symbol byte outside symbol body");

    a_body_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st.phase == PH_BODY |-> r_st.remaining_count != 16'd0)
        else $error("body phase with nothing left to emit");

endmodule

/* rtl/object_record_stream_parser.sv */
// channel | direction | handshake            | payload
// in      | input     | i_in_valid/o_in_stall  | t_in_item  (byte, end flag)
// out     | output    | o_out_valid/i_out_stall | t_out_item (kind, addr, value, last)
//
// One byte a cycle while the output is not stalled: a beat sits in the input
// register while the parser state and result are worked out, then the result
// lands in the output register.
// Reset (synchronous, active low) empties both registers and returns the
// parser to awaiting a header.
// A stalled output holds its result; the input register then fills and
// o_in_stall rises until the output is taken.
module object_record_stream_parser (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  orsp_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output orsp_pkg::t_out_item o_out_item
);
    import orsp_pkg::*;

    logic      r_in_valid;
    t_in_item  r_in;
    logic      r_out_valid;
    t_out_item r_out;
    logic      fire;
    logic      res_valid;
    t_out_item res;

    // the held beat moves on when the output register is free or being taken
    assign fire       = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !fire;

    orsp_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire),
        .i_item      (r_in),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in <= i_in_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= res_valid;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && res_valid) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule
